[rtl/pafp_pkg.sv]
package pafp_pkg;

    localparam logic [1:0] REQ_RESET   = 2'd0;
    localparam logic [1:0] REQ_APPEND  = 2'd1;
    localparam logic [1:0] REQ_ALLOC   = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOFIT    = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;
    localparam logic [1:0] ST_FULL     = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic [1:0] CFG_DYNAMIC = 2'd0;
    localparam logic [1:0] CFG_POLICY  = 2'd1;
    localparam logic [1:0] CFG_MEMSIZE = 2'd2;

    localparam logic [16:0] ADDR_SPACE = 17'h10000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [16:0] request_size;
        logic [15:0] release_base;
        logic [16:0] release_limit;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] granted_base;
        logic [16:0] granted_size;
    } rsp_t;

    typedef struct packed {
        logic [15:0] base;
        logic [16:0] size;
        logic        busy;
    } entry_t;

endpackage

[rtl/pafp_mem.sv]
module pafp_mem #(
    parameter int DEPTH = 32,
    parameter int IW    = 5
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IW-1:0]    waddr,
    input  pafp_pkg::entry_t wdata,
    input  logic [IW-1:0]    raddr,
    output pafp_pkg::entry_t rdata
);

    pafp_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/partition_allocator_fit_policies.sv]
// channel  dir  handshake              payload
// req      in   req_valid/req_ready    pafp_pkg::req_t
// rsp      out  rsp_valid/rsp_ready    pafp_pkg::rsp_t
// cfg      in   cfg_we                 cfg_index, cfg_wdata
//
// reset layout, a first append and requests rejected up front go straight to the result;
// a later append reads the last entry; allocate and release: one scan of the table, one
// memory read a cycle, then the decide state, a shift of the tail for a split or merge,
// the two write states and the result state; the single entry memory port pair paces
// these steps; a reset request leaves one free entry in dynamic mode with a nonzero size
// (else an empty table); a stalled rsp holds the result; the next beat is taken once it is loaded
module partition_allocator_fit_policies #(
    parameter int MAX_PARTITIONS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  pafp_pkg::req_t   req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output pafp_pkg::rsp_t   rsp,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [16:0]      cfg_wdata
);

    localparam int CW = $clog2(MAX_PARTITIONS + 1);
    localparam int IW = $clog2(MAX_PARTITIONS);
    localparam logic [CW-1:0] MAXC = CW'(MAX_PARTITIONS);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LAST   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_WR1    = 3'd5;
    localparam logic [2:0] S_WR2    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]       state_reg;
    pafp_pkg::req_t   req_reg;
    logic [CW-1:0]    count_reg;
    logic             dyn_reg;
    logic [1:0]       pol_reg;
    logic [16:0]      msize_reg;

    logic [CW-1:0]    scan_next_reg;
    logic             rd_valid_reg;
    logic [IW-1:0]    eval_idx_reg;

    logic             found_reg;
    logic [IW-1:0]    pick_reg;
    pafp_pkg::entry_t pick_ent_reg;
    logic [16:0]      waste_reg;
    pafp_pkg::entry_t last_ent_reg;
    pafp_pkg::entry_t prev_ent_reg;
    pafp_pkg::entry_t next_ent_reg;
    logic             has_prev_reg;
    logic             has_next_reg;
    logic             cap_next_reg;

    logic [CW-1:0]    sh_src_reg;
    logic [CW-1:0]    sh_left_reg;
    logic             sh_up_reg;
    logic [1:0]       sh_dist_reg;

    logic             wr1_en_reg;
    logic [IW-1:0]    wr1_addr_reg;
    pafp_pkg::entry_t wr1_data_reg;
    logic             wr2_en_reg;
    logic [IW-1:0]    wr2_addr_reg;
    pafp_pkg::entry_t wr2_data_reg;

    pafp_pkg::rsp_t   res_reg;
    logic             rsp_valid_reg;
    pafp_pkg::rsp_t   rsp_reg;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    pafp_pkg::entry_t mem_wdata;
    logic [IW-1:0]    mem_raddr;
    pafp_pkg::entry_t rd_data;

    logic             accept;
    logic [16:0]      clamp_size;
    logic [17:0]      last_end;
    logic             app_bad_idle;
    logic             app_bad_last;
    logic             fits;
    logic [16:0]      waste_now;
    logic             take_alloc;
    logic             match_rel;
    logic             merge_next;
    logic             merge_prev;
    logic [CW:0]      pick_ext;

    function automatic logic app_bad(input logic [16:0] sz, input logic [17:0] st);
        logic [17:0] room;
        begin
            room = {1'b0, pafp_pkg::ADDR_SPACE} - st;
            app_bad = (sz == 17'd0) || (st >= {1'b0, pafp_pkg::ADDR_SPACE})
                      || ({1'b0, sz} > room);
        end
    endfunction

    assign accept       = req_valid && req_ready;
    assign req_ready    = (state_reg == S_IDLE);
    assign clamp_size   = (msize_reg > pafp_pkg::ADDR_SPACE) ? pafp_pkg::ADDR_SPACE : msize_reg;
    assign last_end     = {2'b00, rd_data.base} + {1'b0, rd_data.size};
    assign app_bad_idle = app_bad(req.request_size, 18'd0);
    assign app_bad_last = app_bad(req_reg.request_size, last_end);
    assign fits         = !rd_data.busy && (rd_data.size >= req_reg.request_size);
    assign waste_now    = rd_data.size - req_reg.request_size;
    assign take_alloc   = fits && (!found_reg
                          || (pol_reg == pafp_pkg::POL_BEST && waste_now < waste_reg)
                          || (pol_reg == pafp_pkg::POL_WORST && waste_now > waste_reg));
    assign match_rel    = (rd_data.base == req_reg.release_base) && (last_end ==
                          {1'b0, req_reg.release_limit});
    assign merge_next   = dyn_reg && has_next_reg && !next_ent_reg.busy;
    assign merge_prev   = dyn_reg && has_prev_reg && !prev_ent_reg.busy;
    assign pick_ext     = {{(CW + 1 - IW){1'b0}}, pick_reg};

    // write port: one writer per state
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.req_type == pafp_pkg::REQ_RESET && dyn_reg
                    && msize_reg != 17'd0)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{base: 16'd0, size: clamp_size, busy: 1'b0};
                end
                else if (accept && req.req_type == pafp_pkg::REQ_APPEND
                         && count_reg == '0 && !app_bad_idle)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = '{base: 16'd0, size: req.request_size, busy: 1'b0};
                end
            end
            S_LAST:
            begin
                mem_we    = !app_bad_last;
                mem_waddr = count_reg[IW-1:0];
                mem_wdata = '{base: last_end[15:0], size: req_reg.request_size, busy: 1'b0};
            end
            S_SHIFT:
            begin
                mem_we    = rd_valid_reg;
                mem_waddr = sh_up_reg ? eval_idx_reg + IW'(1)
                                      : eval_idx_reg - IW'(sh_dist_reg);
                mem_wdata = rd_data;
            end
            S_WR1:
            begin
                mem_we    = wr1_en_reg;
                mem_waddr = wr1_addr_reg;
                mem_wdata = wr1_data_reg;
            end
            S_WR2:
            begin
                mem_we    = wr2_en_reg;
                mem_waddr = wr2_addr_reg;
                mem_wdata = wr2_data_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  mem_raddr = (req.req_type == pafp_pkg::REQ_APPEND)
                                 ? IW'(count_reg - CW'(1)) : '0;
            S_SCAN:  mem_raddr = scan_next_reg[IW-1:0];
            S_SHIFT: mem_raddr = sh_src_reg[IW-1:0];
            default: mem_raddr = '0;
        endcase
    end

    pafp_mem #(
        .DEPTH (MAX_PARTITIONS),
        .IW    (IW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            dyn_reg       <= 1'b1;
            pol_reg       <= pafp_pkg::POL_FIRST;
            msize_reg     <= 17'd4096;
            rd_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    pafp_pkg::CFG_DYNAMIC: dyn_reg   <= cfg_wdata[0];
                    pafp_pkg::CFG_POLICY:  pol_reg   <= cfg_wdata[1:0];
                    pafp_pkg::CFG_MEMSIZE: msize_reg <= cfg_wdata;
                    default:               dyn_reg   <= dyn_reg;
                endcase
            end

            priority if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg              <= req;
                        res_reg.granted_base <= '0;
                        res_reg.granted_size <= '0;
                        found_reg            <= 1'b0;
                        has_prev_reg         <= 1'b0;
                        has_next_reg         <= 1'b0;
                        cap_next_reg         <= 1'b0;
                        waste_reg            <= '0;
                        scan_next_reg        <= CW'(1);
                        eval_idx_reg         <= '0;
                        unique case (req.req_type)
                            pafp_pkg::REQ_RESET:
                            begin
                                res_reg.status <= pafp_pkg::ST_OK;
                                count_reg <= (dyn_reg && msize_reg != 17'd0) ? CW'(1) : '0;
                                state_reg <= S_DONE;
                            end
                            pafp_pkg::REQ_APPEND:
                            begin
                                if (count_reg >= MAXC)
                                begin
                                    res_reg.status <= pafp_pkg::ST_FULL;
                                    state_reg      <= S_DONE;
                                end
                                else if (count_reg == '0)
                                begin
                                    if (app_bad_idle)
                                    begin
                                        res_reg.status <= pafp_pkg::ST_NOFIT;
                                    end
                                    else
                                    begin
                                        res_reg.status <= pafp_pkg::ST_OK;
                                        count_reg      <= CW'(1);
                                    end
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    res_reg.status <= pafp_pkg::ST_OK;
                                    state_reg      <= S_LAST;
                                end
                            end
                            pafp_pkg::REQ_ALLOC:
                            begin
                                if (req.request_size == 17'd0 || count_reg == '0)
                                begin
                                    res_reg.status <= pafp_pkg::ST_NOFIT;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    res_reg.status <= pafp_pkg::ST_OK;
                                    rd_valid_reg   <= 1'b1;
                                    state_reg      <= S_SCAN;
                                end
                            end
                            default:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_reg.status <= pafp_pkg::ST_NOTFOUND;
                                    state_reg      <= S_DONE;
                                end
                                else
                                begin
                                    res_reg.status <= pafp_pkg::ST_OK;
                                    rd_valid_reg   <= 1'b1;
                                    state_reg      <= S_SCAN;
                                end
                            end
                        endcase
                    end
                end

                S_LAST:
                begin
                    if (app_bad_last)
                    begin
                        res_reg.status <= pafp_pkg::ST_NOFIT;
                    end
                    else
                    begin
                        count_reg <= count_reg + CW'(1);
                    end
                    state_reg <= S_DONE;
                end

                S_SCAN:
                begin
                    if (scan_next_reg < count_reg)
                    begin
                        scan_next_reg <= scan_next_reg + CW'(1);
                        eval_idx_reg  <= scan_next_reg[IW-1:0];
                        rd_valid_reg  <= 1'b1;
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b0;
                    end

                    if (rd_valid_reg)
                    begin
                        last_ent_reg <= rd_data;
                        if (req_reg.req_type == pafp_pkg::REQ_ALLOC)
                        begin
                            if (take_alloc)
                            begin
                                found_reg    <= 1'b1;
                                pick_reg     <= eval_idx_reg;
                                pick_ent_reg <= rd_data;
                                waste_reg    <= waste_now;
                            end
                        end
                        else if (!found_reg && match_rel)
                        begin
                            found_reg    <= 1'b1;
                            pick_reg     <= eval_idx_reg;
                            pick_ent_reg <= rd_data;
                            prev_ent_reg <= last_ent_reg;
                            has_prev_reg <= (eval_idx_reg != '0);
                            cap_next_reg <= 1'b1;
                        end
                        else if (cap_next_reg)
                        begin
                            next_ent_reg <= rd_data;
                            has_next_reg <= 1'b1;
                            cap_next_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    wr1_en_reg  <= 1'b0;
                    wr2_en_reg  <= 1'b0;
                    sh_left_reg <= '0;
                    sh_up_reg   <= 1'b0;
                    sh_dist_reg <= 2'd1;
                    state_reg   <= S_SHIFT;
                    if (req_reg.req_type == pafp_pkg::REQ_ALLOC)
                    begin
                        if (!found_reg)
                        begin
                            res_reg.status <= pafp_pkg::ST_NOFIT;
                            state_reg      <= S_DONE;
                        end
                        else if (dyn_reg && waste_reg != 17'd0)
                        begin
                            if (count_reg >= MAXC)
                            begin
                                res_reg.status <= pafp_pkg::ST_FULL;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                // tail moves up one place to open room for the remainder
                                count_reg    <= count_reg + CW'(1);
                                sh_up_reg    <= 1'b1;
                                sh_src_reg   <= count_reg - CW'(1);
                                sh_left_reg  <= CW'({1'b0, count_reg} - pick_ext - (CW + 1)'(1));
                                wr1_en_reg   <= 1'b1;
                                wr1_addr_reg <= pick_reg + IW'(1);
                                wr1_data_reg <= '{base: pick_ent_reg.base
                                                        + req_reg.request_size[15:0],
                                                  size: waste_reg, busy: 1'b0};
                                wr2_en_reg   <= 1'b1;
                                wr2_addr_reg <= pick_reg;
                                wr2_data_reg <= '{base: pick_ent_reg.base,
                                                  size: req_reg.request_size, busy: 1'b1};
                                res_reg.granted_base <= pick_ent_reg.base;
                                res_reg.granted_size <= req_reg.request_size;
                            end
                        end
                        else
                        begin
                            wr2_en_reg   <= 1'b1;
                            wr2_addr_reg <= pick_reg;
                            wr2_data_reg <= '{base: pick_ent_reg.base,
                                              size: pick_ent_reg.size, busy: 1'b1};
                            res_reg.granted_base <= pick_ent_reg.base;
                            res_reg.granted_size <= pick_ent_reg.size;
                        end
                    end
                    else if (!found_reg)
                    begin
                        res_reg.status <= pafp_pkg::ST_NOTFOUND;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        wr1_en_reg <= 1'b1;
                        priority if (merge_next && merge_prev)
                        begin
                            wr1_addr_reg <= pick_reg - IW'(1);
                            wr1_data_reg <= '{base: prev_ent_reg.base,
                                              size: prev_ent_reg.size + pick_ent_reg.size
                                                    + next_ent_reg.size,
                                              busy: 1'b0};
                            sh_src_reg   <= CW'(pick_ext + (CW + 1)'(2));
                            sh_left_reg  <= CW'({1'b0, count_reg} - pick_ext - (CW + 1)'(2));
                            sh_dist_reg  <= 2'd2;
                            count_reg    <= count_reg - CW'(2);
                        end
                        else if (merge_next)
                        begin
                            wr1_addr_reg <= pick_reg;
                            wr1_data_reg <= '{base: pick_ent_reg.base,
                                              size: pick_ent_reg.size + next_ent_reg.size,
                                              busy: 1'b0};
                            sh_src_reg   <= CW'(pick_ext + (CW + 1)'(2));
                            sh_left_reg  <= CW'({1'b0, count_reg} - pick_ext - (CW + 1)'(2));
                            count_reg    <= count_reg - CW'(1);
                        end
                        else if (merge_prev)
                        begin
                            wr1_addr_reg <= pick_reg - IW'(1);
                            wr1_data_reg <= '{base: prev_ent_reg.base,
                                              size: prev_ent_reg.size + pick_ent_reg.size,
                                              busy: 1'b0};
                            sh_src_reg   <= CW'(pick_ext + (CW + 1)'(1));
                            sh_left_reg  <= CW'({1'b0, count_reg} - pick_ext - (CW + 1)'(1));
                            count_reg    <= count_reg - CW'(1);
                        end
                        else
                        begin
                            wr1_addr_reg <= pick_reg;
                            wr1_data_reg <= '{base: pick_ent_reg.base,
                                              size: pick_ent_reg.size, busy: 1'b0};
                        end
                    end
                end

                S_SHIFT:
                begin
                    if (sh_left_reg != '0)
                    begin
                        sh_left_reg  <= sh_left_reg - CW'(1);
                        sh_src_reg   <= sh_up_reg ? sh_src_reg - CW'(1) : sh_src_reg + CW'(1);
                        eval_idx_reg <= sh_src_reg[IW-1:0];
                        rd_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_valid_reg <= 1'b0;
                        if (!rd_valid_reg)
                        begin
                            state_reg <= S_WR1;
                        end
                    end
                end

                S_WR1:
                begin
                    state_reg <= S_WR2;
                end

                S_WR2:
                begin
                    state_reg <= S_DONE;
                end

                default:
                begin
                    if (!rsp_valid_reg || rsp_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && (!rsp_valid_reg || rsp_ready))
        begin
            rsp_reg <= res_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAXC)
        else $error("entry count above table depth");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> count_reg != '0)
        else $error("scan started on an empty table");

    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !rd_valid_reg)
        else $error("read still in flight while idle");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && !rsp_valid_reg |=> state_reg == S_IDLE && rsp_valid_reg)
        else $error("result not loaded into free output slot");

endmodule
